[design/tpg_pkg.sv]
// -----------------------------------------------------------------------------
// tpg_pkg
// Shared types, constants and the CORDIC angle table for the trochoid point
// generator.
// -----------------------------------------------------------------------------
package tpg_pkg;

   // default CORDIC depth and the length of the angle table
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_TABLE_LEN    = 24;

   // field widths
   localparam int ANGLE_W  = 16;   // Q4.12
   localparam int RADIUS_W = 16;   // unsigned Q8.8
   localparam int RATIO_W  = 16;   // Q4.12
   localparam int OFFSET_W = 24;   // Q16.8
   localparam int POINT_W  = 32;   // Q24.8
   localparam int XY_W     = 18;   // CORDIC x / y, Q1.14 with headroom
   localparam int Z_W      = 20;   // CORDIC residual angle, Q.16
   localparam int TERM_W   = 18;   // Q.12 curve terms
   localparam int PROD_W   = RATIO_W + XY_W;        // ratio * sin / cos
   localparam int SCALE_W  = RADIUS_W + 1 + TERM_W; // radius * term

   // fixed-point constants
   localparam logic signed [ANGLE_W:0] PI_Q12     = 17'sd12868;
   localparam logic signed [ANGLE_W:0] TWO_PI_Q12 = 17'sd25736;
   localparam logic signed [Z_W-1:0]   PI_Q16     = 20'sd205887;
   localparam logic signed [Z_W-1:0]   HALF_PI_Q16 = 20'sd102944;
   localparam logic signed [XY_W-1:0]  GAIN_Q14   = 18'sd9949;
   localparam logic signed [TERM_W-1:0] ONE_Q12   = 18'sd4096;

   // configuration register map
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = OFFSET_W;
   localparam logic [CSR_INDEX_W-1:0] REG_RADIUS   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RATIO    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_X = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_Y = 8'd3;

   localparam logic [RADIUS_W-1:0]        RADIUS_RST = 16'd256;
   localparam logic signed [RATIO_W-1:0]  RATIO_RST  = 16'sd4096;

   // word entering the CORDIC pipe
   typedef struct packed {
      logic signed [Z_W-1:0]     z;
      logic                      neg;
      logic signed [ANGLE_W-1:0] angle;
   } cordic_in_type;

   // word leaving the CORDIC pipe
   typedef struct packed {
      logic signed [XY_W-1:0]    cos_val;
      logic signed [XY_W-1:0]    sin_val;
      logic signed [ANGLE_W-1:0] angle;
   } cordic_out_type;

   // round(atan(2^-i) * 65536)
   function automatic logic signed [Z_W-1:0] atan_q16(input int i);
      logic signed [Z_W-1:0] a;
      case (i)
         0:       a = 20'sd51472;
         1:       a = 20'sd30385;
         2:       a = 20'sd16055;
         3:       a = 20'sd8150;
         4:       a = 20'sd4091;
         5:       a = 20'sd2047;
         6:       a = 20'sd1024;
         7:       a = 20'sd512;
         8:       a = 20'sd256;
         9:       a = 20'sd128;
         10:      a = 20'sd64;
         11:      a = 20'sd32;
         12:      a = 20'sd16;
         13:      a = 20'sd8;
         14:      a = 20'sd4;
         15:      a = 20'sd2;
         16:      a = 20'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

[design/tpg_cordic.sv]
// -----------------------------------------------------------------------------
// tpg_cordic
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, followed by a
// sign-restore stage. Each stage holds its word until the next one frees up.
// -----------------------------------------------------------------------------
module tpg_cordic #(
   parameter int CORDIC_STAGES = tpg_pkg::CORDIC_STAGES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  tpg_pkg::cordic_in_type  in_word,
   output logic                    out_valid,
   input  logic                    out_ready,
   output tpg_pkg::cordic_out_type out_word
);

   localparam int N = CORDIC_STAGES;

   logic                             v_ff   [0:N];
   logic                             rdy    [0:N];
   logic signed [tpg_pkg::XY_W-1:0]  x_ff   [0:N-1];
   logic signed [tpg_pkg::XY_W-1:0]  y_ff   [0:N-1];
   logic signed [tpg_pkg::Z_W-1:0]   z_ff   [0:N-1];
   logic                             neg_ff [0:N-1];
   logic signed [tpg_pkg::ANGLE_W-1:0] t_ff [0:N-1];

   tpg_pkg::cordic_out_type out_ff;

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_stage
         logic                               src_v;
         logic signed [tpg_pkg::XY_W-1:0]    src_x, src_y, x_in, y_in;
         logic signed [tpg_pkg::Z_W-1:0]     src_z, z_in;
         logic                               src_neg;
         logic signed [tpg_pkg::ANGLE_W-1:0] src_t;

         if (k == 0) begin : g_first
            assign src_v   = in_valid;
            assign src_x   = tpg_pkg::GAIN_Q14;
            assign src_y   = '0;
            assign src_z   = in_word.z;
            assign src_neg = in_word.neg;
            assign src_t   = in_word.angle;
         end else begin : g_next
            assign src_v   = v_ff[k-1];
            assign src_x   = x_ff[k-1];
            assign src_y   = y_ff[k-1];
            assign src_z   = z_ff[k-1];
            assign src_neg = neg_ff[k-1];
            assign src_t   = t_ff[k-1];
         end

         assign rdy[k] = !v_ff[k] || rdy[k+1];

         always_comb begin
            if (src_z >= 0) begin
               x_in = src_x - (src_y >>> k);
               y_in = src_y + (src_x >>> k);
               z_in = src_z - tpg_pkg::atan_q16(k);
            end else begin
               x_in = src_x + (src_y >>> k);
               y_in = src_y - (src_x >>> k);
               z_in = src_z + tpg_pkg::atan_q16(k);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (rdy[k]) begin
               v_ff[k] <= src_v;
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[k] && src_v) begin
               x_ff[k]   <= x_in;
               y_ff[k]   <= y_in;
               z_ff[k]   <= z_in;
               neg_ff[k] <= src_neg;
               t_ff[k]   <= src_t;
            end
         end
      end
   endgenerate

   // sign restore for angles folded by pi
   assign rdy[N] = !v_ff[N] || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[N] <= 1'b0;
      end else if (rdy[N]) begin
         v_ff[N] <= v_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[N] && v_ff[N-1]) begin
         out_ff.cos_val <= neg_ff[N-1] ? -x_ff[N-1] : x_ff[N-1];
         out_ff.sin_val <= neg_ff[N-1] ? -y_ff[N-1] : y_ff[N-1];
         out_ff.angle   <= t_ff[N-1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[N];
   assign out_word  = out_ff;

   // a free output frees the whole pipe
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !v_ff[N] |-> in_ready)
      else $error("cordic pipe stalls with empty output stage");

   // a held output word stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_word))
      else $error("cordic output changed while stalled");

   // sine and cosine stay near unit magnitude
   a_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_word.cos_val <= 18'sd16500) && (out_word.cos_val >= -18'sd16500)
                 && (out_word.sin_val <= 18'sd16500) && (out_word.sin_val >= -18'sd16500))
      else $error("cordic output out of range");

endmodule

[design/trochoid_point_generator.sv]
// -----------------------------------------------------------------------------
// trochoid_point_generator
// Streams curve parameters t in and trochoid points (x, y) out.
// -----------------------------------------------------------------------------
// Each req word carries t (signed Q4.12 radians); each rsp word carries one
// point x = offset_x + radius*(t - ratio*sin t), y = offset_y + radius*(1 -
// ratio*cos t), both signed Q24.8, truncated. One word is taken per cycle and
// one point leaves per cycle unless rsp stalls; the path is range reduction,
// the one-micro-rotation-per-stage CORDIC, sign restore, two multiply
// stages, the term stage and the offset add. Each stage passes its word on as
// soon as the next stage is empty or moving, so the block keeps taking words
// while a finished point waits on rsp, until full. Registers are written
// through the csr port (index 0 radius, 1 ratio, 2 offset_x, 3 offset_y;
// higher indexes ignored) and must only change while the pipe is empty.
// -----------------------------------------------------------------------------
module trochoid_point_generator #(
   parameter int CORDIC_STAGES = tpg_pkg::CORDIC_STAGES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: [15:0] angle
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,
   // response: [31:0] point_x, [63:32] point_y
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [63:0]                        rsp_tdata,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tpg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tpg_pkg::CSR_DATA_W-1:0]     csr_data
);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic        [tpg_pkg::RADIUS_W-1:0] radius_ff;
   logic signed [tpg_pkg::RATIO_W-1:0]  ratio_ff;
   logic signed [tpg_pkg::OFFSET_W-1:0] offset_x_ff;
   logic signed [tpg_pkg::OFFSET_W-1:0] offset_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= tpg_pkg::RADIUS_RST;
         ratio_ff    <= tpg_pkg::RATIO_RST;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tpg_pkg::REG_RADIUS:   radius_ff   <= csr_data[tpg_pkg::RADIUS_W-1:0];
            tpg_pkg::REG_RATIO:    ratio_ff    <= csr_data[tpg_pkg::RATIO_W-1:0];
            tpg_pkg::REG_OFFSET_X: offset_x_ff <= csr_data;
            tpg_pkg::REG_OFFSET_Y: offset_y_ff <= csr_data;
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // stage ready chain, output end first
   // ---------------------------------------------------------------------
   logic vo_ff, vr_ff, vt_ff, vm_ff, v0_ff;
   logic rdy_o, rdy_r, rdy_t, rdy_m, rdy_0;
   logic cordic_in_ready, cordic_out_valid;

   assign rdy_o = !vo_ff || rsp_tready;
   assign rdy_r = !vr_ff || rdy_o;
   assign rdy_t = !vt_ff || rdy_r;
   assign rdy_m = !vm_ff || rdy_t;
   assign rdy_0 = !v0_ff || cordic_in_ready;

   assign req_tready = rdy_0;

   // ---------------------------------------------------------------------
   // stage 0: reduce t to [-pi, pi], widen to Q.16, fold to [-pi/2, pi/2]
   // ---------------------------------------------------------------------
   logic signed [tpg_pkg::ANGLE_W-1:0] t_req;
   logic signed [tpg_pkg::ANGLE_W:0]   tr;
   logic signed [tpg_pkg::Z_W-1:0]     zw, z0_in;
   logic                               neg0_in;
   tpg_pkg::cordic_in_type             s0_ff;

   assign t_req = req_tdata;

   always_comb begin
      if (t_req > tpg_pkg::PI_Q12) begin
         tr = $signed({t_req[tpg_pkg::ANGLE_W-1], t_req}) - tpg_pkg::TWO_PI_Q12;
      end else if (t_req < -tpg_pkg::PI_Q12) begin
         tr = $signed({t_req[tpg_pkg::ANGLE_W-1], t_req}) + tpg_pkg::TWO_PI_Q12;
      end else begin
         tr = $signed({t_req[tpg_pkg::ANGLE_W-1], t_req});
      end
      // reduced angle is within +-pi, so its low 16 bits carry the value
      zw = {tr[tpg_pkg::ANGLE_W-1:0], 4'b0000};
      if (zw > tpg_pkg::HALF_PI_Q16) begin
         z0_in   = zw - tpg_pkg::PI_Q16;
         neg0_in = 1'b1;
      end else if (zw < -tpg_pkg::HALF_PI_Q16) begin
         z0_in   = zw + tpg_pkg::PI_Q16;
         neg0_in = 1'b1;
      end else begin
         z0_in   = zw;
         neg0_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (rdy_0) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_0 && req_tvalid) begin
         s0_ff.z     <= z0_in;
         s0_ff.neg   <= neg0_in;
         s0_ff.angle <= t_req;
      end
   end

   // ---------------------------------------------------------------------
   // CORDIC: sine and cosine in Q1.14
   // ---------------------------------------------------------------------
   tpg_pkg::cordic_out_type cordic_out;

   tpg_cordic #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .in_ready  (cordic_in_ready),
      .in_word   (s0_ff),
      .out_valid (cordic_out_valid),
      .out_ready (rdy_m),
      .out_word  (cordic_out)
   );

   // ---------------------------------------------------------------------
   // stage m: ratio * sin, ratio * cos (Q.26)
   // ---------------------------------------------------------------------
   logic signed [tpg_pkg::PROD_W-1:0]  prod_s_ff, prod_c_ff;
   logic signed [tpg_pkg::ANGLE_W-1:0] tm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (rdy_m) begin
         vm_ff <= cordic_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_m && cordic_out_valid) begin
         prod_s_ff <= ratio_ff * cordic_out.sin_val;
         prod_c_ff <= ratio_ff * cordic_out.cos_val;
         tm_ff     <= cordic_out.angle;
      end
   end

   // ---------------------------------------------------------------------
   // stage t: Q.12 terms t - mu*sin t and 1 - mu*cos t
   // ---------------------------------------------------------------------
   logic signed [tpg_pkg::PROD_W-1:0] term_x_in, term_y_in;
   logic signed [tpg_pkg::TERM_W-1:0] term_x_ff, term_y_ff;

   assign term_x_in = tpg_pkg::PROD_W'(tm_ff) - (prod_s_ff >>> 14);
   assign term_y_in = tpg_pkg::PROD_W'(tpg_pkg::ONE_Q12) - (prod_c_ff >>> 14);

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff <= 1'b0;
      end else if (rdy_t) begin
         vt_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_t && vm_ff) begin
         term_x_ff <= term_x_in[tpg_pkg::TERM_W-1:0];
         term_y_ff <= term_y_in[tpg_pkg::TERM_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // stage r: radius * term (Q.20)
   // ---------------------------------------------------------------------
   logic signed [tpg_pkg::RADIUS_W:0]  radius_s;
   logic signed [tpg_pkg::SCALE_W-1:0] scale_x_ff, scale_y_ff;

   assign radius_s = $signed({1'b0, radius_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
      end else if (rdy_r) begin
         vr_ff <= vt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_r && vt_ff) begin
         scale_x_ff <= radius_s * term_x_ff;
         scale_y_ff <= radius_s * term_y_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage o: shift to Q.8, add origin, hold for rsp
   // ---------------------------------------------------------------------
   logic signed [tpg_pkg::SCALE_W-1:0] pt_x_in, pt_y_in;
   logic signed [tpg_pkg::POINT_W-1:0] point_x_ff, point_y_ff;

   assign pt_x_in = tpg_pkg::SCALE_W'(offset_x_ff) + (scale_x_ff >>> 12);
   assign pt_y_in = tpg_pkg::SCALE_W'(offset_y_ff) + (scale_y_ff >>> 12);

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (rdy_o) begin
         vo_ff <= vr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_o && vr_ff) begin
         point_x_ff <= pt_x_in[tpg_pkg::POINT_W-1:0];
         point_y_ff <= pt_y_in[tpg_pkg::POINT_W-1:0];
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {point_y_ff, point_x_ff};

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   // an empty output stage lets the whole chain move
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output stage");

   // folded angle sits inside the CORDIC's convergence range
   a_fold: assert property (@(posedge clock) disable iff (reset)
      v0_ff |-> (s0_ff.z <= tpg_pkg::HALF_PI_Q16) && (s0_ff.z >= -tpg_pkg::HALF_PI_Q16))
      else $error("folded angle out of range");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

[bench/tb_trochoid_point_generator.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_trochoid_point_generator
// Self-checking bench for the trochoid point generator. A bit-true predictor
// computes each curve point from the angle and the register copies, a queue
// keeps the points still owed, and every rsp word is matched against the
// oldest one. The run goes through several register settings. Both stream
// sides idle at random.
// -----------------------------------------------------------------------------
module tb_trochoid_point_generator;

   localparam int STAGES = 16;
   localparam int LATENCY = STAGES + 6;
   localparam int PHASES = 9;
   localparam int PHASE_WORDS = 75;

   // indexes outside the register map; writes to them must be dropped
   localparam logic [tpg_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED = 8'd4;
   localparam logic [tpg_pkg::CSR_INDEX_W-1:0] REG_TOP_INDEX = 8'hFF;

   // Q4.12 angle landmarks
   localparam int PI_T = 12868;
   localparam int TWO_PI_T = 25736;
   localparam int HALF_PI_T = 6434;

   // -----------------------------------------------------------------------
   // Register copies, predictor and the queue of points still owed
   // -----------------------------------------------------------------------
   class point_ledger;
      logic [15:0] radius;
      logic signed [15:0] ratio;
      logic signed [23:0] offset_x;
      logic signed [23:0] offset_y;
      logic [63:0] owed_points[$];
      int faults;
      int atan_step[24];

      function new();
         radius = 16'd256;
         ratio = 16'sd4096;
         offset_x = '0;
         offset_y = '0;
         faults = 0;
         // round(atan(2^-i) * 2^16), zero from i = 17 on
         atan_step = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                       256, 128, 64, 32, 16, 8, 4, 2,
                       1, 0, 0, 0, 0, 0, 0, 0};
      endfunction

      function void set_reg(logic [tpg_pkg::CSR_INDEX_W-1:0] idx,
                            logic [tpg_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            tpg_pkg::REG_RADIUS: begin
               radius = data[15:0];
            end
            tpg_pkg::REG_RATIO: begin
               ratio = data[15:0];
            end
            tpg_pkg::REG_OFFSET_X: begin
               offset_x = data;
            end
            tpg_pkg::REG_OFFSET_Y: begin
               offset_y = data;
            end
            default: begin
            end
         endcase
      endfunction

      // {y, x} of the curve point for parameter t, both Q24.8
      function logic [63:0] curve_point(logic signed [15:0] t);
         longint tt, tr, z, cx, sy, nx;
         longint rad, mu, ox, oy, tx, ty, px, py;
         bit flip;
         int i;
         tt = t;
         rad = radius;
         mu = ratio;
         ox = offset_x;
         oy = offset_y;
         // one wrap by 2 pi lands any 16-bit angle in [-pi, pi]
         tr = tt;
         if (tr > PI_T) tr = tr - TWO_PI_T;
         else if (tr < -PI_T) tr = tr + TWO_PI_T;
         z = tr * 16;
         flip = 1'b0;
         if (z > 102944) begin
            z = z - 205887;
            flip = 1'b1;
         end else if (z < -102944) begin
            z = z + 205887;
            flip = 1'b1;
         end
         cx = 9949;
         sy = 0;
         for (i = 0; i < STAGES && i < 24; i++) begin
            if (z >= 0) begin
               nx = cx - (sy >>> i);
               sy = sy + (cx >>> i);
               z = z - atan_step[i];
            end else begin
               nx = cx + (sy >>> i);
               sy = sy - (cx >>> i);
               z = z + atan_step[i];
            end
            cx = nx;
         end
         if (flip) begin
            cx = -cx;
            sy = -sy;
         end
         tx = tt - ((mu * sy) >>> 14);
         ty = 4096 - ((mu * cx) >>> 14);
         px = ox + ((rad * tx) >>> 12);
         py = oy + ((rad * ty) >>> 12);
         return {py[31:0], px[31:0]};
      endfunction

      function void take_angle(logic [15:0] angle);
         owed_points.push_back(curve_point(angle));
      endfunction

      function void match_point(logic [63:0] got);
         logic [63:0] want;
         if (owed_points.size() == 0) begin
            $display("%0t: unexpected point x=%0d y=%0d", $time,
                     $signed(got[31:0]), $signed(got[63:32]));
            faults++;
            return;
         end
         want = owed_points.pop_front();
         if (got[31:0] !== want[31:0]) begin
            $display("%0t: point_x mismatch: expected %0d, got %0d", $time,
                     $signed(want[31:0]), $signed(got[31:0]));
            faults++;
         end
         if (got[63:32] !== want[63:32]) begin
            $display("%0t: point_y mismatch: expected %0d, got %0d", $time,
                     $signed(want[63:32]), $signed(got[63:32]));
            faults++;
         end
      endfunction
   endclass

   // -----------------------------------------------------------------------
   // DUT and its signals
   // -----------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;           // [15:0] angle
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;                // [31:0] point_x, [63:32] point_y
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [tpg_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tpg_pkg::CSR_DATA_W-1:0] csr_data = '0;

   point_ledger board = new();
   bit steady = 1'b0;                     // phase runs with no idling at all

   trochoid_point_generator #(.CORDIC_STAGES(STAGES)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random angle: mostly inside +-2 pi, some anywhere in 16 bits, the rest
   // clustered around the wrap and fold points.
   function automatic logic [15:0] pick_angle();
      int r, near;
      r = $urandom_range(0, 99);
      if (r < 70) return 16'(int'($urandom_range(0, 2 * TWO_PI_T)) - TWO_PI_T);
      if (r < 85) return 16'($urandom);
      case ($urandom_range(0, 6))
         0: near = PI_T;
         1: near = -PI_T;
         2: near = HALF_PI_T;
         3: near = -HALF_PI_T;
         4: near = TWO_PI_T;
         5: near = -TWO_PI_T;
         default: near = 0;
      endcase
      return 16'(near + int'($urandom_range(0, 8)) - 4);
   endfunction

   // -----------------------------------------------------------------------
   // Drivers
   // -----------------------------------------------------------------------
   // Offer one angle word, idling first at random. valid stays up after the
   // handshake so back-to-back words need no extra assignment.
   task automatic send_angle(input logic [15:0] angle);
      int gap;
      gap = steady ? 0 : gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= angle;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_angle(angle);
   endtask

   // One register write; the caller drops csr_valid after a batch.
   task automatic write_reg(input logic [tpg_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [tpg_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_reg(idx, data);
   endtask

   task automatic write_all(input logic [tpg_pkg::CSR_DATA_W-1:0] rad,
                            input logic [tpg_pkg::CSR_DATA_W-1:0] mu,
                            input logic [tpg_pkg::CSR_DATA_W-1:0] ox,
                            input logic [tpg_pkg::CSR_DATA_W-1:0] oy);
      write_reg(tpg_pkg::REG_RADIUS, rad);
      write_reg(tpg_pkg::REG_RATIO, mu);
      write_reg(tpg_pkg::REG_OFFSET_X, ox);
      write_reg(tpg_pkg::REG_OFFSET_Y, oy);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sender holds off until every owed point has come back; the pipe is
   // then empty, since each word yields exactly one point.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.owed_points.size() != 0) @(posedge clock);
   endtask

   // Receiver: ready runs of random length broken by random stalls.
   initial begin
      int run, gap;
      forever begin
         rsp_tready <= 1'b1;
         run = $urandom_range(1, 12);
         repeat (run) @(posedge clock);
         gap = steady ? 0 : gap_len();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.match_point(rsp_tdata);
   end

   // -----------------------------------------------------------------------
   // Stimulus
   // -----------------------------------------------------------------------
   initial begin
      logic signed [15:0] landmarks[$];
      int phase, n;
      landmarks = '{16'sd0, 16'sd1, -16'sd1, 16'sd3217, -16'sd3217,
                    16'sd6433, 16'sd6434, -16'sd6434, 16'sd9651,
                    16'sd12867, 16'sd12868, 16'sd12869, -16'sd12868, -16'sd12869,
                    16'sd19302, 16'sd25735, 16'sd25736, -16'sd25736,
                    16'sd25737, -16'sd25737, 16'sd32767, -16'sd32768,
                    16'sh5555, 16'shAAAA};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings first: radius 1.0, mu 1.0 (a plain cycloid), origin 0
      foreach (landmarks[k]) send_angle(landmarks[k]);
      for (n = 0; n < 40; n++) send_angle(pick_angle());
      drain();

      for (phase = 1; phase < PHASES; phase++) begin
         steady = (phase == 2 || phase == 5);
         case (phase)
            1: begin
               // largest radius and mu, origin at opposite corners
               write_all(24'h00FFFF, 24'h007FFF, 24'h7FFFFF, 24'h800000);
            end
            2: begin
               // zero radius collapses the curve onto the origin
               write_all(24'h000000, 24'h008000, 24'h800000, 24'h7FFFFF);
            end
            3: begin
               // smallest nonzero radius, no tracing offset; stray writes
               // to unmapped indexes must leave every register alone
               write_all(24'h000001, 24'h000000, 24'h000000, 24'h000000);
               write_reg(REG_UNMAPPED, 24'($urandom));
               write_reg(REG_TOP_INDEX, 24'($urandom));
               csr_valid <= 1'b0;
               @(posedge clock);
            end
            default: begin
               // random settings; upper data bits above 16-bit fields are junk
               write_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
            end
         endcase
         for (n = 0; n < PHASE_WORDS; n++) send_angle(pick_angle());
         drain();
      end

      steady = 1'b0;
      repeat (LATENCY + 10) @(posedge clock);
      if (board.faults == 0 && board.owed_points.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

[sim.f]
design/tpg_pkg.sv
design/tpg_cordic.sv
design/trochoid_point_generator.sv
bench/tb_trochoid_point_generator.sv
